/* rtl/pisc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// PI speed controller package
// Shared types, register indexes and arithmetic constants.
// ============================================================================
package pisc_pkg;

    localparam int SPEED_W    = 16;
    localparam int GAIN_W     = 16;
    localparam int INTEG_W    = 20;
    localparam int DUTY_W     = 7;
    localparam int RELOAD_W   = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    localparam int MUL_A_W = 24;
    localparam int MUL_B_W = 16;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    localparam logic [DUTY_W-1:0] DUTY_FULL = 7'd100;

    // Division by one hundred through the reciprocal ceil(2^30 / 100),
    // applied in two twelve-bit halves.
    localparam int          RECIP_SHIFT = 30;
    localparam int          RECIP_SPLIT = 12;
    localparam logic [11:0] RECIP_HI    = 12'hA3D;
    localparam logic [11:0] RECIP_LO    = 12'h70B;

    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_LIMIT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_RUN_DUTY   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DUTY       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PWM_RELOAD     = 3'd5;

    typedef struct packed {
        logic [GAIN_W-1:0]   prop_gain;
        logic [GAIN_W-1:0]   integ_gain;
        logic [INTEG_W-1:0]  integral_limit;
        logic [DUTY_W-1:0]   min_run_duty;
        logic [DUTY_W-1:0]   max_duty;
        logic [RELOAD_W-1:0] pwm_reload;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ERR,
        ST_INTEG,
        ST_IMUL,
        ST_DRIVE,
        ST_CLAMP,
        ST_CMUL,
        ST_RLO,
        ST_RHI,
        ST_QUOT
    } state_t;

endpackage
`default_nettype wire

/* rtl/pisc_cfg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// PI speed controller configuration registers
// Holds the gains, limits and PWM reload written over the register channel.
// ============================================================================
module pisc_cfg
    import pisc_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.prop_gain      <= 16'd256;
            cfg_reg.integ_gain     <= 16'd26;
            cfg_reg.integral_limit <= 20'd1000;
            cfg_reg.min_run_duty   <= 7'd10;
            cfg_reg.max_duty       <= 7'd100;
            cfg_reg.pwm_reload     <= 16'd999;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_PROP_GAIN:      cfg_reg.prop_gain      <= cfg_wdata[GAIN_W-1:0];
                REG_INTEG_GAIN:     cfg_reg.integ_gain     <= cfg_wdata[GAIN_W-1:0];
                REG_INTEGRAL_LIMIT: cfg_reg.integral_limit <= cfg_wdata[INTEG_W-1:0];
                REG_MIN_RUN_DUTY:   cfg_reg.min_run_duty   <= cfg_wdata[DUTY_W-1:0];
                REG_MAX_DUTY:       cfg_reg.max_duty       <= cfg_wdata[DUTY_W-1:0];
                REG_PWM_RELOAD:     cfg_reg.pwm_reload     <= cfg_wdata[RELOAD_W-1:0];
                default: begin
                end
            endcase
        end
    end

endmodule
`default_nettype wire

/* rtl/pisc_mul.sv */
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// PI speed controller shared multiplier
// One registered unsigned multiplier used by the multiply steps of the sequence.
// ============================================================================
module pisc_mul
    import pisc_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               mul_en,
    input  wire logic [MUL_A_W-1:0] mul_a,
    input  wire logic [MUL_B_W-1:0] mul_b,
    output logic      [MUL_P_W-1:0] mul_prod
);

    logic [MUL_P_W-1:0] prod_reg;

    assign mul_prod = prod_reg;

    always_ff @(posedge aclk) begin
        if (mul_en) begin
            prod_reg <= {{MUL_B_W{1'b0}}, mul_a} * {{MUL_A_W{1'b0}}, mul_b};
        end
    end

endmodule
`default_nettype wire

/* rtl/pi_speed_controller_pwm_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// PI speed controller with PWM output
// PI loop with a clamped integral, duty clamping and PWM compare calculation.
// ============================================================================
//  Channel  Direction  Handshake              Contents
//  s_       in         s_valid / s_ready      target, measured speed, clear
//  m_       out        m_valid / m_ready      duty, compare level, pins
//  cfg_     in         cfg_valid / cfg_ready  register index and write data
//
//  The result is registered once the sequencer has stepped five products
//  through the one shared multiplier, and a new item is taken only after
//  the sequencer has returned to idle from its last step.
//  The result sits in an output register, so the next item is accepted
//  while it waits; a stalled result holds the sequencer in its last step.
//  Reset sets the registers to their defaults and clears the integral.
// ============================================================================
module pi_speed_controller_pwm_core
    import pisc_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [SPEED_W-1:0]    s_target_speed,
    input  wire logic [SPEED_W-1:0]    s_measured_speed,
    input  wire logic                  s_clear_integral,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic      [DUTY_W-1:0]     m_duty_out,
    output logic      [RELOAD_W-1:0]   m_compare_level,
    output logic                       m_run_direction,
    output logic                       m_standby_pin,
    output logic                       m_dir_pin_a,
    output logic                       m_dir_pin_b,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    cfg_t cfg;

    state_t state_reg, state_next;

    logic [SPEED_W-1:0]  tgt_reg;
    logic [SPEED_W-1:0]  meas_reg;
    logic                clr_reg;
    logic signed [16:0]  err_reg;
    logic [INTEG_W-1:0]  integ_reg;
    logic signed [24:0]  pterm_reg;
    logic signed [29:0]  drive_reg;
    logic [DUTY_W-1:0]   duty_reg;
    logic [22:0]         x_reg;
    logic [34:0]         part_reg;

    logic                m_valid_reg;
    logic [DUTY_W-1:0]   duty_out_reg;
    logic [RELOAD_W-1:0] cmp_reg;
    logic                run_reg;

    logic               mul_en;
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [MUL_P_W-1:0] mul_prod;

    logic               out_free;
    logic [INTEG_W-1:0] integ_base;
    logic signed [21:0] integ_sum;
    logic signed [21:0] integ_lim;
    logic [16:0]        err_mag;
    logic [23:0]        p_mag;
    logic signed [29:0] min_ext;
    logic signed [29:0] max_ext;
    logic signed [29:0] drive_lo;
    logic signed [29:0] drive_hi;
    logic [DUTY_W-1:0]  duty_clamped;
    logic [46:0]        quot_total;
    logic [16:0]        quot;
    logic [RELOAD_W-1:0] cmp_value;

    pisc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    pisc_mul u_mul (
        .aclk     (aclk),
        .mul_en   (mul_en),
        .mul_a    (mul_a),
        .mul_b    (mul_b),
        .mul_prod (mul_prod)
    );

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (s_valid) state_next = ST_ERR;
            ST_ERR:   state_next = ST_INTEG;
            ST_INTEG: state_next = ST_IMUL;
            ST_IMUL:  state_next = ST_DRIVE;
            ST_DRIVE: state_next = ST_CLAMP;
            ST_CLAMP: state_next = ST_CMUL;
            ST_CMUL:  state_next = ST_RLO;
            ST_RLO:   state_next = ST_RHI;
            ST_RHI:   state_next = ST_QUOT;
            ST_QUOT:  if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready = 1'b0;
        mul_en  = 1'b0;
        mul_a   = '0;
        mul_b   = '0;
        unique case (state_reg)
            ST_IDLE: s_ready = 1'b1;
            ST_INTEG: begin
                mul_en = 1'b1;
                mul_a  = {8'd0, err_mag[15:0]};
                mul_b  = cfg.prop_gain;
            end
            ST_IMUL: begin
                mul_en = 1'b1;
                mul_a  = {4'd0, integ_reg};
                mul_b  = cfg.integ_gain;
            end
            ST_CMUL: begin
                mul_en = 1'b1;
                mul_a  = {7'd0, {1'b0, cfg.pwm_reload} + 17'd1};
                mul_b  = {9'd0, duty_reg};
            end
            ST_RLO: begin
                mul_en = 1'b1;
                mul_a  = {1'b0, mul_prod[22:0]};
                mul_b  = {4'd0, RECIP_LO};
            end
            ST_RHI: begin
                mul_en = 1'b1;
                mul_a  = {1'b0, x_reg};
                mul_b  = {4'd0, RECIP_HI};
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        integ_base = clr_reg ? '0 : integ_reg;
        integ_sum  = $signed({2'b00, integ_base}) + {{5{err_reg[16]}}, err_reg};
        integ_lim  = $signed({2'b00, cfg.integral_limit});
        err_mag    = err_reg[16] ? 17'(-err_reg) : 17'(err_reg);
        p_mag      = mul_prod[31:8];

        min_ext  = $signed({23'd0, cfg.min_run_duty});
        max_ext  = $signed({23'd0, cfg.max_duty});
        drive_lo = (drive_reg < min_ext) ? min_ext : drive_reg;
        drive_hi = (drive_lo > max_ext) ? max_ext : drive_lo;
        if (tgt_reg == '0) begin
            duty_clamped = '0;
        end else if (drive_hi[DUTY_W-1:0] > DUTY_FULL) begin
            duty_clamped = DUTY_FULL;
        end else begin
            duty_clamped = drive_hi[DUTY_W-1:0];
        end

        quot_total = {mul_prod[34:0], {RECIP_SPLIT{1'b0}}} + {12'd0, part_reg};
        quot       = quot_total[46:RECIP_SHIFT];
        cmp_value  = (quot > {1'b0, cfg.pwm_reload}) ? cfg.pwm_reload : quot[15:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            integ_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_INTEG) begin
                if (integ_sum > integ_lim) begin
                    integ_reg <= cfg.integral_limit;
                end else if (integ_sum[21]) begin
                    integ_reg <= '0;
                end else begin
                    integ_reg <= integ_sum[INTEG_W-1:0];
                end
            end
            if (state_reg == ST_QUOT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                tgt_reg  <= s_target_speed;
                meas_reg <= s_measured_speed;
                clr_reg  <= s_clear_integral;
            end
            ST_ERR: err_reg <= $signed({1'b0, tgt_reg}) - $signed({1'b0, meas_reg});
            ST_IMUL: begin
                pterm_reg <= err_reg[16] ? -$signed({1'b0, p_mag}) : $signed({1'b0, p_mag});
            end
            ST_DRIVE: begin
                drive_reg <= {{5{pterm_reg[24]}}, pterm_reg} + $signed({2'b00, mul_prod[35:8]});
            end
            ST_CLAMP: duty_reg <= duty_clamped;
            ST_RLO:   x_reg <= mul_prod[22:0];
            ST_RHI:   part_reg <= mul_prod[34:0];
            ST_QUOT: begin
                if (out_free) begin
                    duty_out_reg <= duty_reg;
                    cmp_reg      <= cmp_value;
                    run_reg      <= (tgt_reg != '0);
                end
            end
            default: begin
            end
        endcase
    end

    assign m_valid         = m_valid_reg;
    assign m_duty_out      = duty_out_reg;
    assign m_compare_level = cmp_reg;
    assign m_run_direction = run_reg;
    assign m_standby_pin   = run_reg;
    assign m_dir_pin_a     = run_reg;
    assign m_dir_pin_b     = 1'b0;

`ifndef NO_ASSERTIONS
    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_ERR))
        else $error("Accepted item did not start the sequence.");

    a_integ_clamped: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_INTEG) |=> (integ_reg <= $past(cfg.integral_limit)))
        else $error("Integral exceeds its limit after the update.");

    a_duty_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_duty_out <= DUTY_FULL))
        else $error("Duty above one hundred percent.");

    a_stop_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_run_direction) |-> (m_duty_out == '0 && m_compare_level == '0))
        else $error("Stopped result with non-zero drive.");
`endif

endmodule
`default_nettype wire

/* bench/testbench.sv */
`timescale 1ns / 1ps
// ============================================================================
// PI speed controller testbench
// Drives control ticks and register writes into the PI speed controller core
// with random pacing on both channels. Every result is checked, field by
// field, against a PI loop model kept in step with the block: a directed
// table of corner cases comes first, then closed-loop speed runs mixed with
// random noise under a range of gain, limit, duty and reload settings.
// ============================================================================
module testbench;
    import pisc_pkg::*;

    typedef struct packed {
        logic [DUTY_W-1:0]   duty;
        logic [RELOAD_W-1:0] compare;
        logic                run_dir;
        logic                standby;
        logic                pin_a;
        logic                pin_b;
    } motor_cmd_t;

    typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        logic                  typed;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_data;
        logic [SPEED_W-1:0]    target;
        logic [SPEED_W-1:0]    measured;
        logic                  clear;
        motor_cmd_t            want;
    } plan_row_t;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;
    localparam motor_cmd_t STOPPED = '0;
    localparam int SETTLE_CYCLES = 14;
    localparam int PHASES = 9;
    localparam int TICKS_PER_PHASE = 150;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [SPEED_W-1:0]    s_target_speed = '0;
    logic [SPEED_W-1:0]    s_measured_speed = '0;
    logic                  s_clear_integral = 1'b0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [DUTY_W-1:0]     m_duty_out;
    logic [RELOAD_W-1:0]   m_compare_level;
    logic                  m_run_direction;
    logic                  m_standby_pin;
    logic                  m_dir_pin_a;
    logic                  m_dir_pin_b;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    cfg_t               cfg_model;
    logic [INTEG_W-1:0] integ_model;
    motor_cmd_t         pending_cmds[$];
    plan_row_t          plan[$];
    bit                 pace_on = 1'b1;
    int                 fail_count = 0;
    int                 ticks_sent = 0;
    int                 cmds_seen = 0;
    int                 writes_done = 0;
    logic [SPEED_W-1:0] run_target = '0;
    int                 run_left = 0;

    pi_speed_controller_pwm_core u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_target_speed   (s_target_speed),
        .s_measured_speed (s_measured_speed),
        .s_clear_integral (s_clear_integral),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_duty_out       (m_duty_out),
        .m_compare_level  (m_compare_level),
        .m_run_direction  (m_run_direction),
        .m_standby_pin    (m_standby_pin),
        .m_dir_pin_a      (m_dir_pin_a),
        .m_dir_pin_b      (m_dir_pin_b),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic motor_cmd_t running(input int duty, input int compare);
        motor_cmd_t cmd;
        cmd = '0;
        cmd.duty = duty[DUTY_W-1:0];
        cmd.compare = compare[RELOAD_W-1:0];
        cmd.run_dir = 1'b1;
        cmd.standby = 1'b1;
        cmd.pin_a = 1'b1;
        return cmd;
    endfunction

    function automatic void reset_model();
        cfg_model.prop_gain = 16'd256;
        cfg_model.integ_gain = 16'd26;
        cfg_model.integral_limit = 20'd1000;
        cfg_model.min_run_duty = 7'd10;
        cfg_model.max_duty = 7'd100;
        cfg_model.pwm_reload = 16'd999;
        integ_model = '0;
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_PROP_GAIN:      cfg_model.prop_gain = data[GAIN_W-1:0];
            REG_INTEG_GAIN:     cfg_model.integ_gain = data[GAIN_W-1:0];
            REG_INTEGRAL_LIMIT: cfg_model.integral_limit = data[INTEG_W-1:0];
            REG_MIN_RUN_DUTY:   cfg_model.min_run_duty = data[DUTY_W-1:0];
            REG_MAX_DUTY:       cfg_model.max_duty = data[DUTY_W-1:0];
            REG_PWM_RELOAD:     cfg_model.pwm_reload = data[RELOAD_W-1:0];
            default: ;
        endcase
    endfunction

    // One control tick of the PI loop; advances the modelled integral.
    function automatic motor_cmd_t pi_tick(input logic [SPEED_W-1:0] target,
                                           input logic [SPEED_W-1:0] measured,
                                           input logic clear);
        longint err;
        longint acc;
        longint mag;
        longint pterm;
        longint iterm;
        longint drive;
        longint duty;
        longint compare;
        motor_cmd_t cmd;
        err = longint'({48'd0, target}) - longint'({48'd0, measured});
        if (clear) begin
            integ_model = '0;
        end
        acc = longint'({44'd0, integ_model}) + err;
        if (acc > longint'({44'd0, cfg_model.integral_limit})) begin
            acc = longint'({44'd0, cfg_model.integral_limit});
        end
        if (acc < 0) begin
            acc = 0;
        end
        integ_model = acc[INTEG_W-1:0];
        mag = (err < 0) ? -err : err;
        mag = (mag * longint'({48'd0, cfg_model.prop_gain})) >> 8;
        pterm = (err < 0) ? -mag : mag;
        iterm = (longint'({44'd0, integ_model}) * longint'({48'd0, cfg_model.integ_gain})) >> 8;
        drive = pterm + iterm;
        if (drive < longint'({57'd0, cfg_model.min_run_duty})) begin
            drive = longint'({57'd0, cfg_model.min_run_duty});
        end
        if (drive > longint'({57'd0, cfg_model.max_duty})) begin
            drive = longint'({57'd0, cfg_model.max_duty});
        end
        if (target == '0) begin
            return STOPPED;
        end
        duty = (drive > 100) ? 100 : drive;
        compare = ((longint'({48'd0, cfg_model.pwm_reload}) + 1) * duty) / 100;
        if (compare > longint'({48'd0, cfg_model.pwm_reload})) begin
            compare = longint'({48'd0, cfg_model.pwm_reload});
        end
        cmd = running(int'(duty), int'(compare));
        return cmd;
    endfunction

    function automatic void tick_row(input int target, input int measured, input bit clear);
        plan_row_t row;
        row = '0;
        row.kind = ROW_TICK;
        row.target = target[SPEED_W-1:0];
        row.measured = measured[SPEED_W-1:0];
        row.clear = clear;
        plan.push_back(row);
    endfunction

    function automatic void typed_row(input int target, input int measured, input bit clear,
                                      input motor_cmd_t want);
        tick_row(target, measured, clear);
        plan[$].typed = 1'b1;
        plan[$].want = want;
    endfunction

    function automatic void write_row(input logic [CFG_IDX_W-1:0] idx, input int data);
        plan_row_t row;
        row = '0;
        row.kind = ROW_WRITE;
        row.reg_idx = idx;
        row.reg_data = data[CFG_DATA_W-1:0];
        plan.push_back(row);
    endfunction

    task automatic send_tick(input logic [SPEED_W-1:0] target,
                             input logic [SPEED_W-1:0] measured,
                             input logic clear, input logic typed, input motor_cmd_t want);
        int gap;
        motor_cmd_t cmd;
        gap = pace_on ? $urandom_range(0, 18) : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_target_speed <= target;
        s_measured_speed <= measured;
        s_clear_integral <= clear;
        do @(posedge aclk); while (!s_ready);
        cmd = pi_tick(target, measured, clear);
        pending_cmds.push_back(typed ? want : cmd);
        ticks_sent++;
    endtask

    // Lets every outstanding result drain so that registers change only while idle.
    task automatic settle();
        s_valid <= 1'b0;
        while (pending_cmds.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        apply_reg(idx, data);
        writes_done++;
        @(posedge aclk);
    endtask

    function automatic int pick(input int lo_max, input int full_max);
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0) begin
            return 0;
        end else if (sel == 1) begin
            return full_max;
        end else if (sel < 7) begin
            return $urandom_range(0, lo_max);
        end
        return $urandom_range(0, full_max);
    endfunction

    task automatic random_setup(input int phase);
        int prop;
        int integ;
        int limit;
        int lo_duty;
        int hi_duty;
        int reload;
        prop = pick(1024, 65535);
        integ = pick(256, 65535);
        limit = pick(20000, 1048575);
        lo_duty = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 40);
        hi_duty = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 127) : $urandom_range(50, 100);
        reload = pick(2000, 65535);
        if (phase == 0) begin
            prop = 0;
            integ = 0;
            limit = 0;
            lo_duty = 0;
            hi_duty = 0;
            reload = 0;
        end else if (phase == 1) begin
            prop = 65535;
            integ = 65535;
            limit = 1048575;
            lo_duty = 127;
            hi_duty = 127;
            reload = 65535;
        end
        // Upper bits beyond each register's width must be ignored.
        write_reg(REG_PROP_GAIN, CFG_DATA_W'(prop) | (CFG_DATA_W'($urandom_range(0, 15)) << 16));
        write_reg(REG_INTEG_GAIN, CFG_DATA_W'(integ) | (CFG_DATA_W'($urandom_range(0, 15)) << 16));
        write_reg(REG_INTEGRAL_LIMIT, CFG_DATA_W'(limit));
        write_reg(REG_MIN_RUN_DUTY, CFG_DATA_W'(lo_duty) | (CFG_DATA_W'($urandom) << 7));
        write_reg(REG_MAX_DUTY, CFG_DATA_W'(hi_duty) | (CFG_DATA_W'($urandom) << 7));
        write_reg(REG_PWM_RELOAD, CFG_DATA_W'(reload) | (CFG_DATA_W'($urandom_range(0, 15)) << 16));
        write_reg(REG_SPARE, CFG_DATA_W'($urandom));
    endtask

    // Mostly closed-loop runs: a held target, measured speed wandering around it.
    task automatic random_tick();
        logic [SPEED_W-1:0] target;
        logic [SPEED_W-1:0] measured;
        logic               clear;
        int                 sel;
        int                 spread;
        int                 meas;
        sel = $urandom_range(0, 99);
        clear = 1'b0;
        if (sel < 70) begin
            if (run_left == 0) begin
                run_target = ($urandom_range(0, 5) == 0) ? SPEED_W'($urandom)
                                                         : SPEED_W'($urandom_range(1, 6000));
                run_left = $urandom_range(4, 30);
                clear = 1'b1;
            end
            run_left--;
            spread = ($urandom_range(0, 3) == 0) ? 3000 : 200;
            meas = int'(run_target) + $urandom_range(0, 2 * spread) - spread;
            meas = (meas < 0) ? 0 : ((meas > 65535) ? 65535 : meas);
            target = run_target;
            measured = SPEED_W'(meas);
            clear = clear | ($urandom_range(0, 29) == 0);
        end else if (sel < 80) begin
            target = '0;
            measured = SPEED_W'($urandom);
        end else if (sel < 88) begin
            target = ($urandom_range(0, 1) == 0) ? '1 : SPEED_W'($urandom_range(0, 1));
            measured = ($urandom_range(0, 1) == 0) ? '1 : SPEED_W'($urandom_range(0, 1));
            clear = 1'($urandom);
        end else begin
            target = SPEED_W'($urandom);
            measured = SPEED_W'($urandom);
            clear = 1'($urandom);
        end
        send_tick(target, measured, clear, 1'b0, STOPPED);
    endtask

    task automatic take_cmd();
        motor_cmd_t want;
        cmds_seen++;
        if (pending_cmds.size() == 0) begin
            $error("result transfer with no result outstanding");
            fail_count++;
        end else begin
            want = pending_cmds.pop_front();
            if (m_duty_out !== want.duty) begin
                $error("duty_out: expected %0d, actual %0d", want.duty, m_duty_out);
                fail_count++;
            end
            if (m_compare_level !== want.compare) begin
                $error("compare_level: expected %0d, actual %0d", want.compare, m_compare_level);
                fail_count++;
            end
            if (m_run_direction !== want.run_dir) begin
                $error("run_direction: expected %0d, actual %0d", want.run_dir, m_run_direction);
                fail_count++;
            end
            if (m_standby_pin !== want.standby) begin
                $error("standby_pin: expected %0d, actual %0d", want.standby, m_standby_pin);
                fail_count++;
            end
            if (m_dir_pin_a !== want.pin_a) begin
                $error("dir_pin_a: expected %0d, actual %0d", want.pin_a, m_dir_pin_a);
                fail_count++;
            end
            if (m_dir_pin_b !== want.pin_b) begin
                $error("dir_pin_b: expected %0d, actual %0d", want.pin_b, m_dir_pin_b);
                fail_count++;
            end
        end
    endtask

    initial begin
        int stall;
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = pace_on ? $urandom_range(0, 18) : 0;
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            take_cmd();
        end
    end

    initial begin
        #2_000_000;
        $display("Timed out with %0d results outstanding.", pending_cmds.size());
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        reset_model();

        typed_row(0, 0, 0, STOPPED);
        typed_row(0, 65535, 0, STOPPED);
        typed_row(65535, 0, 0, running(100, 999));
        typed_row(65535, 65535, 1, running(10, 100));
        typed_row(1, 65535, 0, running(10, 100));
        tick_row(16'hAAAA, 16'h5555, 0);
        tick_row(16'h5555, 16'hAAAA, 0);
        tick_row(3000, 2900, 1);
        tick_row(3000, 2950, 0);
        typed_row(0, 120, 0, STOPPED);
        tick_row(3000, 3000, 0);
        write_row(REG_PROP_GAIN, 0);
        write_row(REG_INTEG_GAIN, 65535);
        tick_row(2000, 1990, 1);
        write_row(REG_MIN_RUN_DUTY, 60);
        write_row(REG_MAX_DUTY, 40);
        typed_row(100, 100, 1, running(40, 400));
        write_row(REG_MIN_RUN_DUTY, 127);
        write_row(REG_MAX_DUTY, 127);
        typed_row(100, 100, 0, running(100, 999));
        write_row(REG_PWM_RELOAD, 0);
        typed_row(500, 0, 0, running(100, 0));
        write_row(REG_PWM_RELOAD, 65535);
        tick_row(500, 400, 0);
        write_row(REG_MIN_RUN_DUTY, 0);
        write_row(REG_MAX_DUTY, 100);
        write_row(REG_PROP_GAIN, 256);
        write_row(REG_INTEG_GAIN, 26);
        tick_row(65535, 0, 0);
        write_row(REG_INTEGRAL_LIMIT, 200);
        tick_row(1000, 1000, 0);
        write_row(REG_INTEGRAL_LIMIT, 20'hFFFFF);
        write_row(REG_PROP_GAIN, 20'hFFFFF);
        write_row(REG_SPARE, 20'h5A5A5);
        tick_row(65535, 0, 0);
        tick_row(65535, 0, 0);
        write_row(REG_MAX_DUTY, 0);
        tick_row(5, 0, 0);

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_WRITE) begin
                settle();
                write_reg(plan[i].reg_idx, plan[i].reg_data);
            end else begin
                send_tick(plan[i].target, plan[i].measured, plan[i].clear,
                          plan[i].typed, plan[i].want);
            end
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            settle();
            random_setup(phase);
            pace_on = (phase % 3) != 1;
            for (int n = 0; n < TICKS_PER_PHASE; n++) begin
                random_tick();
            end
        end

        settle();
        repeat (20) @(posedge aclk);
        $display("Sent %0d control ticks and checked %0d results across %0d register writes.",
                 ticks_sent, cmds_seen, writes_done);
        $display("Covered the directed corner cases and %0d random register setups.", PHASES);
        if (fail_count == 0 && pending_cmds.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
